/* src/cfde_pkg.sv */
// Shared types, constants and tables of the comma field decimal extractor.
package cfde_pkg;

	// Default values of the top-level parameters.
	localparam int MAX_FIELDS_DEF  = 32;
	localparam int FRAC_DIGITS_DEF = 5;
	localparam int VALUE_WIDTH_DEF = 40;

	// Selector registers and configuration port.
	localparam int NUM_SEL   = 6;
	localparam int SEL_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam logic [SEL_W-1:0] SEL_RESET [NUM_SEL] =
		'{5'd3, 5'd5, 5'd7, 5'd15, 5'd16, 5'd18};

	// Slots of the captured value registers.
	localparam int IDX_LATITUDE  = 0;
	localparam int IDX_LONGITUDE = 1;
	localparam int IDX_ALTITUDE  = 2;
	localparam int IDX_HDOP      = 3;
	localparam int IDX_VDOP      = 4;
	localparam int IDX_SAT       = 5;

	// Fixed field widths.
	localparam int CNT_W  = 6;
	localparam int SAT_W  = 8;
	localparam int FD_W   = 3;
	localparam int IP_W   = 8;
	localparam int BYTE_W = 8;

	// Queue between the classifier and the parser.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Characters with a meaning of their own.
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'd44;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
	localparam logic [BYTE_W-1:0] CH_VTAB  = 8'd11;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'd12;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [BYTE_W-1:0] CH_POINT = 8'd46;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

	// Byte classes produced by the front end.
	typedef enum logic [2:0] {
		CL_LF,
		CL_COMMA,
		CL_CR,
		CL_BLANK,
		CL_SIGN,
		CL_POINT,
		CL_DIGIT,
		CL_OTHER
	} class_t;

	// Number parser phase within one field.
	typedef enum logic [1:0] {
		PH_START,
		PH_INT,
		PH_FRAC,
		PH_STOP
	} phase_t;

	// One classified byte as it travels through the queue.
	typedef struct packed {
		class_t     cls;
		logic       minus;
		logic [3:0] digit;
	} item_t;

	// Powers of ten up to the largest fraction width.
	function automatic logic [31:0] pow10(input int n);
		logic [31:0] p;
		case (n)
			0: p = 32'd1;
			1: p = 32'd10;
			2: p = 32'd100;
			3: p = 32'd1000;
			4: p = 32'd10000;
			5: p = 32'd100000;
			6: p = 32'd1000000;
			7: p = 32'd10000000;
			default: p = 32'd1;
		endcase
		return p;
	endfunction

endpackage

/* src/cfde_front.sv */
// Front end: accepts received bytes and classifies them for the parser.
module cfde_front (
	input  logic                        byte_valid,
	input  logic [cfde_pkg::BYTE_W-1:0] data_byte,
	output logic                        byte_stall,
	input  logic                        q_full,
	output logic                        push,
	output cfde_pkg::item_t             push_item
);

	// A byte is taken whenever the queue has room.
	assign byte_stall = q_full;
	assign push       = byte_valid && !q_full;

	// Sort the byte into one of the classes the parser acts on.
	always_comb begin
		push_item.minus = (data_byte == cfde_pkg::CH_MINUS);
		push_item.digit = data_byte[3:0];
		case (data_byte)
			cfde_pkg::CH_LF:    push_item.cls = cfde_pkg::CL_LF;
			cfde_pkg::CH_COMMA: push_item.cls = cfde_pkg::CL_COMMA;
			cfde_pkg::CH_CR:    push_item.cls = cfde_pkg::CL_CR;
			cfde_pkg::CH_SPACE,
			cfde_pkg::CH_TAB,
			cfde_pkg::CH_VTAB,
			cfde_pkg::CH_FF:    push_item.cls = cfde_pkg::CL_BLANK;
			cfde_pkg::CH_MINUS,
			cfde_pkg::CH_PLUS:  push_item.cls = cfde_pkg::CL_SIGN;
			cfde_pkg::CH_POINT: push_item.cls = cfde_pkg::CL_POINT;
			default: begin
				if (data_byte >= cfde_pkg::CH_ZERO && data_byte <= cfde_pkg::CH_NINE) begin
					push_item.cls = cfde_pkg::CL_DIGIT;
				end else begin
					push_item.cls = cfde_pkg::CL_OTHER;
				end
			end
		endcase
	end

endmodule

/* src/cfde_queue.sv */
// Short queue of classified bytes between the front end and the parser.
module cfde_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  cfde_pkg::item_t push_item,
	output logic            q_full,
	output logic            q_valid,
	output cfde_pkg::item_t q_item,
	input  logic            pop
);

	cfde_pkg::item_t                 entries_q [cfde_pkg::QUEUE_DEPTH];
	logic [cfde_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [cfde_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [cfde_pkg::QCNT_W-1:0]     count_q;

	// Status seen by both neighbors.
	assign q_full  = (count_q == cfde_pkg::QCNT_W'(cfde_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = entries_q[rd_ptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + cfde_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + cfde_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + cfde_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - cfde_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

/* src/cfde_back.sv */
// Back end: sentence tracking, number parsing, field capture and result register.
module cfde_back #(
	parameter int MAX_FIELDS  = cfde_pkg::MAX_FIELDS_DEF,
	parameter int FRAC_DIGITS = cfde_pkg::FRAC_DIGITS_DEF,
	parameter int VALUE_WIDTH = cfde_pkg::VALUE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [cfde_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cfde_pkg::SEL_W-1:0]     cfg_data,
	input  logic                           q_valid,
	input  cfde_pkg::item_t                q_item,
	output logic                           pop,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic signed [VALUE_WIDTH-1:0]  latitude,
	output logic signed [VALUE_WIDTH-1:0]  longitude,
	output logic signed [VALUE_WIDTH-1:0]  altitude,
	output logic signed [VALUE_WIDTH-1:0]  hdop,
	output logic signed [VALUE_WIDTH-1:0]  vdop,
	output logic signed [cfde_pkg::SAT_W-1:0] satellites,
	output logic [cfde_pkg::CNT_W-1:0]     fields_seen
);

	localparam int AW      = VALUE_WIDTH - 1;
	localparam int SW      = VALUE_WIDTH + 3;
	localparam int CNT_CAP = (MAX_FIELDS > 63) ? 63 : MAX_FIELDS;
	localparam int NVAL    = cfde_pkg::NUM_SEL - 1;
	localparam int FD_W_PAD = cfde_pkg::FD_W;
	localparam logic [SW-1:0] VMAX_EXT = SW'({AW{1'b1}});
	localparam logic [SW-1:0] POW_INT  = SW'(cfde_pkg::pow10(FRAC_DIGITS));

	// Configuration and parser state.
	logic [cfde_pkg::SEL_W-1:0]    sel_q [cfde_pkg::NUM_SEL];
	logic                          synced_q, synced_n;
	logic [cfde_pkg::CNT_W-1:0]    cnt_q, cnt_n;
	cfde_pkg::phase_t              phase_q, phase_n;
	logic                          neg_q, neg_n;
	logic [cfde_pkg::FD_W-1:0]     fd_q, fd_n;
	logic [AW-1:0]                 acc_q, acc_n;
	logic [cfde_pkg::IP_W-1:0]     ip_q, ip_n;
	logic [VALUE_WIDTH-1:0]        cap_q [NVAL];
	logic [VALUE_WIDTH-1:0]        cap_n [NVAL];
	logic [cfde_pkg::SAT_W-1:0]    sat_q, sat_n;

	// Result register.
	logic                          result_valid_q;
	logic [VALUE_WIDTH-1:0]        res_q [NVAL];
	logic [cfde_pkg::SAT_W-1:0]    res_sat_q;
	logic [cfde_pkg::CNT_W-1:0]    res_cnt_q;

	// Datapath intermediates.
	logic                          out_free, is_cr, load;
	logic [SW-1:0]                 add_int, add_frac, sum_int, sum_frac;
	logic [FD_W_PAD-1:0]           pow_sel;
	logic [11:0]                   ip_ext;
	logic                          cnt_in_range;
	logic [VALUE_WIDTH-1:0]        signed_val;
	logic [cfde_pkg::SAT_W-1:0]    sat_val;
	logic [VALUE_WIDTH-1:0]        cap_fin [NVAL];
	logic [cfde_pkg::SAT_W-1:0]    sat_fin;
	logic                          start_skip, start_sign;
	cfde_pkg::phase_t              eph;

	// Handshake with the queue and the result side.
	assign out_free = !result_valid_q || !result_stall;
	assign is_cr    = (q_item.cls == cfde_pkg::CL_CR);
	assign pop      = q_valid && (!(is_cr && synced_q) || out_free);
	assign load     = pop && is_cr && synced_q;

	// Digit addends and the two candidate accumulator sums.
	assign pow_sel  = cfde_pkg::FD_W'(FRAC_DIGITS - 1) - fd_q;
	assign add_int  = SW'(q_item.digit) * POW_INT;
	assign add_frac = SW'(q_item.digit) * SW'(cfde_pkg::pow10(int'(pow_sel)));
	assign sum_int  = SW'({acc_q, 3'b000}) + SW'({acc_q, 1'b0}) + add_int;
	assign sum_frac = SW'(acc_q) + add_frac;

	// Integer part tracked on its own for the satellite count.
	assign ip_ext = 12'({ip_q, 3'b000}) + 12'({ip_q, 1'b0}) + 12'(q_item.digit);

	// Value of the field in progress, signed and as a clipped integer.
	always_comb begin
		signed_val = neg_q ? (VALUE_WIDTH'(0) - VALUE_WIDTH'(acc_q)) : VALUE_WIDTH'(acc_q);
		if (neg_q) begin
			sat_val = (ip_q >= 8'd128) ? 8'h80 : (8'd0 - ip_q);
		end else begin
			sat_val = (ip_q > 8'd127) ? 8'd127 : ip_q;
		end
	end

	// Capture of the finished field into every slot that selects it.
	assign cnt_in_range = ({1'b0, cnt_q} < 7'(MAX_FIELDS));
	always_comb begin
		for (int i = 0; i < NVAL; i++) begin
			if (cnt_in_range && ({1'b0, sel_q[i]} == cnt_q)) begin
				cap_fin[i] = signed_val;
			end else begin
				cap_fin[i] = cap_q[i];
			end
		end
		if (cnt_in_range && ({1'b0, sel_q[cfde_pkg::IDX_SAT]} == cnt_q)) begin
			sat_fin = sat_val;
		end else begin
			sat_fin = sat_q;
		end
	end

	// Next state of the sentence tracker and the number parser.
	assign start_skip = (phase_q == cfde_pkg::PH_START) && (q_item.cls == cfde_pkg::CL_BLANK);
	assign start_sign = (phase_q == cfde_pkg::PH_START) && (q_item.cls == cfde_pkg::CL_SIGN);
	assign eph        = (phase_q == cfde_pkg::PH_START) ? cfde_pkg::PH_INT : phase_q;

	always_comb begin
		synced_n = synced_q;
		cnt_n    = cnt_q;
		phase_n  = phase_q;
		neg_n    = neg_q;
		fd_n     = fd_q;
		acc_n    = acc_q;
		ip_n     = ip_q;
		cap_n    = cap_q;
		sat_n    = sat_q;
		if (pop) begin
			case (q_item.cls)
				cfde_pkg::CL_LF: begin
					synced_n = 1'b1;
					cnt_n    = '0;
					phase_n  = cfde_pkg::PH_START;
					neg_n    = 1'b0;
					fd_n     = '0;
					acc_n    = '0;
					ip_n     = '0;
					for (int i = 0; i < NVAL; i++) begin
						cap_n[i] = '0;
					end
					sat_n = '0;
				end
				cfde_pkg::CL_COMMA: begin
					if (synced_q) begin
						cap_n = cap_fin;
						sat_n = sat_fin;
						if (cnt_q < cfde_pkg::CNT_W'(CNT_CAP)) begin
							cnt_n = cnt_q + cfde_pkg::CNT_W'(1);
						end
						phase_n = cfde_pkg::PH_START;
						neg_n   = 1'b0;
						fd_n    = '0;
						acc_n   = '0;
						ip_n    = '0;
					end
				end
				cfde_pkg::CL_CR: begin
					if (synced_q) begin
						cap_n    = cap_fin;
						sat_n    = sat_fin;
						synced_n = 1'b0;
						cnt_n    = '0;
						phase_n  = cfde_pkg::PH_START;
						neg_n    = 1'b0;
						fd_n     = '0;
						acc_n    = '0;
						ip_n     = '0;
					end
				end
				default: begin
					if (synced_q && start_sign) begin
						neg_n   = q_item.minus;
						phase_n = cfde_pkg::PH_INT;
					end else if (synced_q && !start_skip) begin
						case (eph)
							cfde_pkg::PH_INT: begin
								phase_n = cfde_pkg::PH_INT;
								if (q_item.cls == cfde_pkg::CL_DIGIT) begin
									acc_n = (sum_int > VMAX_EXT) ? {AW{1'b1}} : sum_int[AW-1:0];
									ip_n  = (ip_ext > 12'd255) ? 8'd255 : ip_ext[7:0];
								end else if (q_item.cls == cfde_pkg::CL_POINT) begin
									phase_n = cfde_pkg::PH_FRAC;
								end else begin
									phase_n = cfde_pkg::PH_STOP;
								end
							end
							cfde_pkg::PH_FRAC: begin
								if (q_item.cls == cfde_pkg::CL_DIGIT) begin
									if (fd_q < cfde_pkg::FD_W'(FRAC_DIGITS)) begin
										acc_n = (sum_frac > VMAX_EXT) ? {AW{1'b1}}
											: sum_frac[AW-1:0];
										fd_n  = fd_q + cfde_pkg::FD_W'(1);
									end
								end else begin
									phase_n = cfde_pkg::PH_STOP;
								end
							end
							default: begin
								phase_n = phase_q;
							end
						endcase
					end
				end
			endcase
		end
	end

	// Selector registers, written from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cfde_pkg::NUM_SEL; i++) begin
				sel_q[i] <= cfde_pkg::SEL_RESET[i];
			end
		end else if (cfg_write && (cfg_index < cfde_pkg::CFG_IDX_W'(cfde_pkg::NUM_SEL))) begin
			sel_q[cfg_index] <= cfg_data;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q <= 1'b0;
			cnt_q    <= '0;
			phase_q  <= cfde_pkg::PH_START;
			neg_q    <= 1'b0;
			fd_q     <= '0;
			acc_q    <= '0;
			ip_q     <= '0;
			for (int i = 0; i < NVAL; i++) begin
				cap_q[i] <= '0;
			end
			sat_q    <= '0;
		end else begin
			synced_q <= synced_n;
			cnt_q    <= cnt_n;
			phase_q  <= phase_n;
			neg_q    <= neg_n;
			fd_q     <= fd_n;
			acc_q    <= acc_n;
			ip_q     <= ip_n;
			cap_q    <= cap_n;
			sat_q    <= sat_n;
		end
	end

	// Result valid flag: set on a sentence end, cleared once the transfer is made.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= load;
		end
	end

	// Result payload, loaded only when the register is free.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q     <= cap_fin;
			res_sat_q <= sat_fin;
			res_cnt_q <= cnt_q;
		end
	end

	assign result_valid = result_valid_q;
	assign latitude     = res_q[cfde_pkg::IDX_LATITUDE];
	assign longitude    = res_q[cfde_pkg::IDX_LONGITUDE];
	assign altitude     = res_q[cfde_pkg::IDX_ALTITUDE];
	assign hdop         = res_q[cfde_pkg::IDX_HDOP];
	assign vdop         = res_q[cfde_pkg::IDX_VDOP];
	assign satellites   = res_sat_q;
	assign fields_seen  = res_cnt_q;

`ifndef NO_ASSERTIONS
	// A sentence end leaves a result waiting and the tracker unsynced.
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (result_valid_q && !synced_q && (cnt_q == '0)))
		else $error("sentence end did not produce a result or reset the tracker");

	// A line feed restarts the sentence with an empty accumulator.
	a_lf_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (q_item.cls == cfde_pkg::CL_LF)) |=> (synced_q && (cnt_q == '0) && (acc_q == '0)))
		else $error("line feed did not restart the sentence");

	// The integer part tracker is nonzero only with a nonzero accumulator.
	a_ip_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(ip_q != '0) |-> (acc_q != '0))
		else $error("integer part and accumulator disagree");

	// Fraction digits are counted only once the point has been seen.
	a_fd_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(fd_q != '0) |-> ((phase_q == cfde_pkg::PH_FRAC) || (phase_q == cfde_pkg::PH_STOP)))
		else $error("fraction digits counted outside the fraction");
`endif

endmodule

/* src/comma_field_decimal_extractor.sv */
// Top level of the comma field decimal extractor.
//
// The block takes one received byte per clock cycle on the byte channel while
// the queue has room, and gives one result for each carriage return that ends
// a sentence opened by a line feed. The sustained rate is one byte per cycle,
// set by the accumulate step (a wide add and saturating compare) in the back
// end. A carriage return passes through a queue entry and is then loaded into
// the result register, from which the result is offered; a waiting result
// blocks only a further carriage return: other bytes keep flowing while the
// result side stalls, up to the four-entry queue between the classifier and
// the parser.
// Values are fixed point with FRAC_DIGITS decimal fraction digits.
module comma_field_decimal_extractor #(
	parameter int MAX_FIELDS  = cfde_pkg::MAX_FIELDS_DEF,
	parameter int FRAC_DIGITS = cfde_pkg::FRAC_DIGITS_DEF,
	parameter int VALUE_WIDTH = cfde_pkg::VALUE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [cfde_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfde_pkg::SEL_W-1:0]        cfg_data,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [cfde_pkg::BYTE_W-1:0]       data_byte,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic signed [VALUE_WIDTH-1:0]     latitude,
	output logic signed [VALUE_WIDTH-1:0]     longitude,
	output logic signed [VALUE_WIDTH-1:0]     altitude,
	output logic signed [VALUE_WIDTH-1:0]     hdop,
	output logic signed [VALUE_WIDTH-1:0]     vdop,
	output logic signed [cfde_pkg::SAT_W-1:0] satellites,
	output logic [cfde_pkg::CNT_W-1:0]        fields_seen
);

	logic            push;
	cfde_pkg::item_t push_item;
	logic            q_full;
	logic            q_valid;
	cfde_pkg::item_t q_item;
	logic            pop;

	// Byte classifier.
	cfde_front u_front (
		.byte_valid (byte_valid),
		.data_byte  (data_byte),
		.byte_stall (byte_stall),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	// Decoupling queue.
	cfde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	// Parser and result register.
	cfde_back #(
		.MAX_FIELDS  (MAX_FIELDS),
		.FRAC_DIGITS (FRAC_DIGITS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.latitude     (latitude),
		.longitude    (longitude),
		.altitude     (altitude),
		.hdop         (hdop),
		.vdop         (vdop),
		.satellites   (satellites),
		.fields_seen  (fields_seen)
	);

endmodule

/* verif/cfde_checker.sv */
`timescale 1ns / 100ps
// Checker that predicts and compares the fix reports of the comma field decimal extractor.
module cfde_checker (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_write,
	input  logic [cfde_pkg::CFG_IDX_W-1:0]              cfg_index,
	input  logic [cfde_pkg::SEL_W-1:0]                  cfg_data,
	input  logic                                        byte_valid,
	input  logic                                        byte_stall,
	input  logic [cfde_pkg::BYTE_W-1:0]                 data_byte,
	input  logic                                        result_valid,
	input  logic                                        result_stall,
	input  logic signed [cfde_pkg::VALUE_WIDTH_DEF-1:0] latitude,
	input  logic signed [cfde_pkg::VALUE_WIDTH_DEF-1:0] longitude,
	input  logic signed [cfde_pkg::VALUE_WIDTH_DEF-1:0] altitude,
	input  logic signed [cfde_pkg::VALUE_WIDTH_DEF-1:0] hdop,
	input  logic signed [cfde_pkg::VALUE_WIDTH_DEF-1:0] vdop,
	input  logic signed [cfde_pkg::SAT_W-1:0]           satellites,
	input  logic [cfde_pkg::CNT_W-1:0]                  fields_seen,
	output int                                          fail_count,
	output int                                          pending,
	output int                                          fixes_checked
);

	localparam int VW = cfde_pkg::VALUE_WIDTH_DEF;
	localparam int FRAC = cfde_pkg::FRAC_DIGITS_DEF;
	localparam int SAT_W = cfde_pkg::SAT_W;
	localparam int CNT_W = cfde_pkg::CNT_W;
	localparam int BYTE_W = cfde_pkg::BYTE_W;
	localparam longint unsigned MAG_MAX = (64'd1 << (VW - 1)) - 64'd1;
	localparam int FIELD_CAP = (cfde_pkg::MAX_FIELDS_DEF > 63) ? 63 : cfde_pkg::MAX_FIELDS_DEF;

	// One fix report as the block should present it.
	typedef struct packed {
		logic [VW-1:0]    latitude;
		logic [VW-1:0]    longitude;
		logic [VW-1:0]    altitude;
		logic [VW-1:0]    hdop;
		logic [VW-1:0]    vdop;
		logic [SAT_W-1:0] satellites;
		logic [CNT_W-1:0] fields_seen;
	} fix_t;

	fix_t                       expected_fixes[$];
	logic [cfde_pkg::SEL_W-1:0] sel_field [cfde_pkg::NUM_SEL];
	longint unsigned            captured [cfde_pkg::NUM_SEL];
	logic                       in_sentence;
	int                         field_no;
	cfde_pkg::phase_t           number_phase;
	logic                       negative;
	int                         frac_count;
	longint unsigned            magnitude;

	function automatic longint unsigned decade(input int n);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < n; i++)
			p = p * 10;
		return p;
	endfunction

	task automatic report_failure(input string msg);
		fail_count++;
		$display("[%0t] %s", $time, msg);
	endtask

	task automatic check_value(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_failure($sformatf("fix %0d: %s is 0x%0h, expected 0x%0h",
				fixes_checked, name, got, want));
	endtask

	task automatic clear_number();
		number_phase = cfde_pkg::PH_START;
		negative = 1'b0;
		frac_count = 0;
		magnitude = 0;
	endtask

	// A field ends: every selector naming it takes the value parsed so far.
	task automatic close_field();
		longint unsigned whole;
		if (field_no >= cfde_pkg::MAX_FIELDS_DEF)
			return;
		for (int i = 0; i < cfde_pkg::NUM_SEL; i++) begin
			if (int'(sel_field[i]) != field_no)
				continue;
			if (i == cfde_pkg::IDX_SAT) begin
				whole = magnitude / decade(FRAC);
				if (negative && whole > 128)
					whole = 128;
				if (!negative && whole > 127)
					whole = 127;
				captured[i] = negative ? (0 - whole) : whole;
			end else begin
				captured[i] = negative ? (0 - magnitude) : magnitude;
			end
		end
	endtask

	// Number reading in the manner of atof, with saturation of the magnitude.
	task automatic feed_number(input logic [BYTE_W-1:0] b);
		logic            is_digit;
		longint unsigned digit_val;
		longint unsigned add;
		is_digit = (b >= cfde_pkg::CH_ZERO) && (b <= cfde_pkg::CH_NINE);
		digit_val = is_digit ? 64'(b - cfde_pkg::CH_ZERO) : 64'd0;
		if (number_phase == cfde_pkg::PH_START) begin
			if (b == cfde_pkg::CH_SPACE || b == cfde_pkg::CH_TAB ||
				b == cfde_pkg::CH_VTAB || b == cfde_pkg::CH_FF)
				return;
			if (b == cfde_pkg::CH_MINUS || b == cfde_pkg::CH_PLUS) begin
				negative = (b == cfde_pkg::CH_MINUS);
				number_phase = cfde_pkg::PH_INT;
				return;
			end
			number_phase = cfde_pkg::PH_INT;
		end
		if (number_phase == cfde_pkg::PH_INT) begin
			if (is_digit) begin
				add = digit_val * decade(FRAC);
				if (magnitude > (MAG_MAX - add) / 10)
					magnitude = MAG_MAX;
				else
					magnitude = magnitude * 10 + add;
			end else if (b == cfde_pkg::CH_POINT) begin
				number_phase = cfde_pkg::PH_FRAC;
			end else begin
				number_phase = cfde_pkg::PH_STOP;
			end
			return;
		end
		if (number_phase == cfde_pkg::PH_FRAC) begin
			if (is_digit) begin
				if (frac_count < FRAC) begin
					add = digit_val * decade(FRAC - 1 - frac_count);
					magnitude = (magnitude > MAG_MAX - add) ? MAG_MAX : magnitude + add;
					frac_count++;
				end
			end else begin
				number_phase = cfde_pkg::PH_STOP;
			end
		end
	endtask

	// Advance the sentence state by one transferred byte.
	task automatic predict_byte(input logic [BYTE_W-1:0] b);
		fix_t fix;
		if (b == cfde_pkg::CH_LF) begin
			in_sentence = 1'b1;
			field_no = 0;
			clear_number();
			foreach (captured[i])
				captured[i] = 0;
			return;
		end
		if (!in_sentence)
			return;
		if (b == cfde_pkg::CH_COMMA) begin
			close_field();
			if (field_no < FIELD_CAP)
				field_no++;
			clear_number();
			return;
		end
		if (b == cfde_pkg::CH_CR) begin
			close_field();
			fix.latitude = VW'(captured[cfde_pkg::IDX_LATITUDE]);
			fix.longitude = VW'(captured[cfde_pkg::IDX_LONGITUDE]);
			fix.altitude = VW'(captured[cfde_pkg::IDX_ALTITUDE]);
			fix.hdop = VW'(captured[cfde_pkg::IDX_HDOP]);
			fix.vdop = VW'(captured[cfde_pkg::IDX_VDOP]);
			fix.satellites = SAT_W'(captured[cfde_pkg::IDX_SAT]);
			fix.fields_seen = CNT_W'(field_no);
			expected_fixes.push_back(fix);
			in_sentence = 1'b0;
			field_no = 0;
			clear_number();
			return;
		end
		feed_number(b);
	endtask

	// Compare one transferred fix report with the oldest expectation.
	task automatic check_fix();
		fix_t want;
		if (expected_fixes.size() == 0) begin
			report_failure($sformatf("fix report with none expected (fields_seen %0d)",
				fields_seen));
			return;
		end
		want = expected_fixes.pop_front();
		check_value("latitude", 64'($unsigned(latitude)), 64'(want.latitude));
		check_value("longitude", 64'($unsigned(longitude)), 64'(want.longitude));
		check_value("altitude", 64'($unsigned(altitude)), 64'(want.altitude));
		check_value("hdop", 64'($unsigned(hdop)), 64'(want.hdop));
		check_value("vdop", 64'($unsigned(vdop)), 64'(want.vdop));
		check_value("satellites", 64'($unsigned(satellites)), 64'(want.satellites));
		check_value("fields_seen", 64'(fields_seen), 64'(want.fields_seen));
	endtask

	// Watch configuration writes and both channels at every edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (sel_field[i])
				sel_field[i] = cfde_pkg::SEL_RESET[i];
			foreach (captured[i])
				captured[i] = 0;
			in_sentence = 1'b0;
			field_no = 0;
			clear_number();
			expected_fixes.delete();
			fail_count = 0;
			pending <= 0;
			fixes_checked <= 0;
		end else begin
			if (cfg_write && cfg_index < cfde_pkg::NUM_SEL)
				sel_field[cfg_index] = cfg_data;
			if (byte_valid && !byte_stall)
				predict_byte(data_byte);
			if (result_valid && !result_stall) begin
				check_fix();
				fixes_checked <= fixes_checked + 1;
			end
			pending <= expected_fixes.size();
		end
	end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Stimulus, clock, reset and verdict for the comma field decimal extractor.
module tb_top;

	localparam int VW = cfde_pkg::VALUE_WIDTH_DEF;
	localparam int NUM_SEL = cfde_pkg::NUM_SEL;
	localparam int CFG_IDX_W = cfde_pkg::CFG_IDX_W;
	localparam int SEL_W = cfde_pkg::SEL_W;
	localparam int BYTE_W = cfde_pkg::BYTE_W;
	localparam int SAT_W = cfde_pkg::SAT_W;
	localparam int CNT_W = cfde_pkg::CNT_W;
	localparam int ITEMS = 1450;
	localparam int MIN_PHASES = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT = 800000;
	localparam int CFG_IDX_SPARE = NUM_SEL;
	localparam int SEL_TOP = 31;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [SEL_W-1:0]         cfg_data = '0;
	logic                     byte_valid = 1'b0;
	logic                     byte_stall;
	logic [BYTE_W-1:0]        data_byte = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	logic signed [VW-1:0]     latitude;
	logic signed [VW-1:0]     longitude;
	logic signed [VW-1:0]     altitude;
	logic signed [VW-1:0]     hdop;
	logic signed [VW-1:0]     vdop;
	logic signed [SAT_W-1:0]  satellites;
	logic [CNT_W-1:0]         fields_seen;

	int fail_count;
	int pending;
	int fixes_checked;
	int bytes_sent = 0;
	int holds_asked = 0;
	int settings_used = 0;
	int sel_now [NUM_SEL];
	bit send_quiet = 1'b0;
	logic [BYTE_W-1:0] line_q[$];

	comma_field_decimal_extractor i_dut (.*);

	cfde_checker i_checker (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// Run limit.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d fixes outstanding", cycles, pending);
		$display("FAILED: results differ");
		$finish;
	end

	// Result side: random stalls before each transfer, quiet stretches, long hold-offs on request.
	initial begin : fix_taker
		int  gap;
		int  taken;
		int  holds_done;
		bit  take_quiet;
		taken = 0;
		holds_done = 0;
		take_quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 8 == 0)
				take_quiet = ($urandom_range(3) == 0);
			if (holds_done != holds_asked) begin
				gap = HOLD_CYCLES;
				holds_done++;
			end else begin
				gap = take_quiet ? 0 : $urandom_range(11, 0);
			end
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do begin
				@(posedge clk);
			end while (!(result_valid && !result_stall));
			taken++;
		end
	end

	// One byte transfer, after a random number of idle cycles.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(11, 0);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		do begin
			@(posedge clk);
		end while (!(byte_valid && !byte_stall));
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_sentence(input string s);
		send_byte(cfde_pkg::CH_LF);
		send_text(s);
		send_byte(cfde_pkg::CH_CR);
	endtask

	// Wait until every fix has been transferred and the queue inside has emptied.
	task automatic settle_block();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all six selectors from sel_now, then one write to an unused index.
	task automatic load_selectors();
		for (int i = 0; i < NUM_SEL; i++) begin
			cfg_write <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= SEL_W'(sel_now[i]);
			@(posedge clk);
		end
		cfg_index <= CFG_IDX_W'(CFG_IDX_SPARE + $urandom_range(1));
		cfg_data <= SEL_W'($urandom_range(SEL_TOP));
		@(posedge clk);
		cfg_write <= 1'b0;
		settings_used++;
	endtask

	task automatic set_all_selectors(input int value);
		foreach (sel_now[i])
			sel_now[i] = value;
		load_selectors();
	endtask

	// Any byte that neither separates nor frames a field.
	function automatic logic [BYTE_W-1:0] field_byte();
		logic [BYTE_W-1:0] b;
		do begin
			b = BYTE_W'($urandom_range(255));
		end while (b == cfde_pkg::CH_LF || b == cfde_pkg::CH_CR || b == cfde_pkg::CH_COMMA);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] digit_byte();
		return cfde_pkg::CH_ZERO + BYTE_W'($urandom_range(9));
	endfunction

	// Append one field's text: mostly well-formed numbers, some empty or junk.
	task automatic add_number();
		int roll;
		int n_int;
		int n_frac;
		roll = $urandom_range(99);
		if (roll < 8)
			return;
		if (roll < 16) begin
			repeat ($urandom_range(4, 1)) line_q.push_back(field_byte());
			return;
		end
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: line_q.push_back(cfde_pkg::CH_SPACE);
				1: line_q.push_back(cfde_pkg::CH_TAB);
				2: line_q.push_back(cfde_pkg::CH_VTAB);
				default: line_q.push_back(cfde_pkg::CH_FF);
			endcase
		end
		roll = $urandom_range(9);
		if (roll < 3)
			line_q.push_back(cfde_pkg::CH_MINUS);
		else if (roll < 5)
			line_q.push_back(cfde_pkg::CH_PLUS);
		// Long integer parts push the magnitude into saturation.
		n_int = ($urandom_range(9) == 0) ? $urandom_range(16, 6) : $urandom_range(5);
		repeat (n_int) line_q.push_back(digit_byte());
		if ($urandom_range(9) < 7) begin
			line_q.push_back(cfde_pkg::CH_POINT);
			n_frac = $urandom_range(8);
			repeat (n_frac) line_q.push_back(digit_byte());
		end
		if ($urandom_range(9) == 0) begin
			line_q.push_back(field_byte());
			line_q.push_back(digit_byte());
		end
	endtask

	// Build and send one sentence sized to reach the selected fields.
	task automatic send_random_sentence();
		int top_sel;
		int n_fields;
		int roll;
		bit chosen;
		line_q.delete();
		send_quiet = ($urandom_range(3) == 0);
		top_sel = 0;
		foreach (sel_now[i])
			if (sel_now[i] > top_sel)
				top_sel = sel_now[i];
		roll = $urandom_range(99);
		if (roll < 12) begin
			repeat ($urandom_range(4, 1)) line_q.push_back(BYTE_W'($urandom_range(255)));
		end else if (roll < 20) begin
			// A sentence cut short by a new line feed.
			line_q.push_back(cfde_pkg::CH_LF);
			add_number();
			line_q.push_back(cfde_pkg::CH_COMMA);
			add_number();
		end
		line_q.push_back(cfde_pkg::CH_LF);
		if ($urandom_range(7) == 0)
			n_fields = $urandom_range(45);
		else
			n_fields = top_sel - 2 + $urandom_range(6);
		if (n_fields < 1)
			n_fields = 1;
		for (int k = 0; k < n_fields; k++) begin
			if (k > 0)
				line_q.push_back(cfde_pkg::CH_COMMA);
			chosen = 1'b0;
			foreach (sel_now[i])
				if (sel_now[i] == k)
					chosen = 1'b1;
			if (chosen || $urandom_range(6) == 0)
				add_number();
		end
		// Most sentences close with a carriage return; the rest are dropped by the next line feed.
		if ($urandom_range(11) != 0)
			line_q.push_back(cfde_pkg::CH_CR);
		foreach (line_q[j])
			send_byte(line_q[j]);
	endtask

	initial begin : stimulus
		int phase_no;
		int n_sentences;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sentences. Bytes before any line feed are ignored.
		send_text("$GP");
		send_byte(cfde_pkg::CH_CR);
		// Selectors at reset values; hdop, vdop and satellites are missing.
		send_sentence(",,,4916.45,,-12311.12,,-12.5");
		settle_block();
		foreach (sel_now[i])
			sel_now[i] = i;
		load_selectors();
		// Truncated fraction, lone sign, lone point, leading blanks, letters, satellite clamp.
		send_sentence("+1.234567,-,.,\t 42,abc,300");
		// Saturation of both signs, stop at other characters, negative satellite clamp.
		send_sentence("99999999999999,-99999999999999,7x5,12.34.5,0,-200");
		// A line feed in mid sentence restarts it.
		send_byte(cfde_pkg::CH_LF);
		send_text("5,5");
		send_sentence("7,8,9");
		// Carriage return without a line feed gives nothing.
		send_text("1,2");
		send_byte(cfde_pkg::CH_CR);
		settle_block();
		// Every selector on the last field, with the comma count saturating past it.
		set_all_selectors(SEL_TOP);
		send_byte(cfde_pkg::CH_LF);
		repeat (SEL_TOP) send_byte(cfde_pkg::CH_COMMA);
		send_text("7");
		repeat (9) send_byte(cfde_pkg::CH_COMMA);
		send_byte(cfde_pkg::CH_CR);
		settle_block();

		// Random phases, each with its own selector setting.
		phase_no = 0;
		while (phase_no < MIN_PHASES || bytes_sent < ITEMS) begin
			case (phase_no % 6)
				0: begin
					foreach (sel_now[i])
						sel_now[i] = int'(cfde_pkg::SEL_RESET[i]);
					load_selectors();
				end
				1: set_all_selectors(0);
				2: set_all_selectors(SEL_TOP);
				default: begin
					foreach (sel_now[i])
						sel_now[i] = ($urandom_range(1) == 0) ?
							$urandom_range(12) : $urandom_range(SEL_TOP);
					load_selectors();
				end
			endcase
			n_sentences = $urandom_range(3, 2);
			// Long receiver hold-off while sentences keep coming, so the input stalls.
			if (phase_no == 1 || phase_no == 4) begin
				holds_asked <= holds_asked + 1;
				n_sentences = 5;
			end
			repeat (n_sentences) send_random_sentence();
			settle_block();
			phase_no++;
		end

		$display("Covered %0d input bytes under %0d selector settings and %0d long hold-offs.",
			bytes_sent, settings_used, holds_asked);
		$display("Compared %0d fix reports field by field; %0d mismatches.",
			fixes_checked, fail_count);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* filelist.f */
src/cfde_pkg.sv
src/cfde_front.sv
src/cfde_queue.sv
src/cfde_back.sv
src/comma_field_decimal_extractor.sv
verif/cfde_checker.sv
verif/tb_top.sv
